// ===== rtl/mmr_pkg.sv =====
package mmr_pkg;

    localparam int PORT_COUNT    = 5;
    localparam int QUEUE_DEPTH   = 8;
    localparam int TABLE_ENTRIES = 16;

    localparam int QW      = $clog2(QUEUE_DEPTH);
    localparam int TW      = $clog2(TABLE_ENTRIES);
    localparam int QADDR_W = 3 + QW;
    localparam int Q_ENTRIES = PORT_COUNT * QUEUE_DEPTH;
    localparam int QDATA_W = 60;
    localparam int NUM_W   = 13;
    localparam int DEN_W   = 8;

    // Input item codes
    localparam logic [1:0] FUNC_ARRIVE = 2'd0;
    localparam logic [1:0] FUNC_CREDIT = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_TABLE  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_COPY   = 2'd0;
    localparam logic [1:0] KIND_CREDIT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_QUEUE_OVF  = 2'd0;
    localparam logic [1:0] ERR_ROUTE_MISS = 2'd1;
    localparam logic [1:0] ERR_CREDIT_OVF = 2'd2;
    localparam logic [1:0] ERR_CREDIT_UNF = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_NODE_ID   = 3'd0;
    localparam logic [2:0] REG_QUEUE_CAP = 3'd1;
    localparam logic [2:0] REG_FLIT_B    = 3'd2;
    localparam logic [2:0] REG_ROUTE_DLY = 3'd3;
    localparam logic [2:0] REG_OUT_DLY   = 3'd4;
    localparam logic [2:0] REG_LINKS     = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  port;
        logic [15:0] key;
        logic [11:0] bytes;
        logic [7:0]  node;
        logic [15:0] cores;
        logic [1:0]  err;
    } t_res;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    // Table mask bit that selects output port p (local is the top bit)
    function automatic logic [2:0] out_bit(input logic [2:0] p);
        logic [2:0] r;
        if (p == 3'd0) begin
            r = 3'd4;
        end else begin
            r = p - 3'd1;
        end
        return r;
    endfunction

    // Next port index modulo the port count, for values below twice the count
    function automatic logic [2:0] mod_ports(input logic [3:0] v);
        logic [3:0] r;
        if (v >= 4'(PORT_COUNT)) begin
            r = v - 4'(PORT_COUNT);
        end else begin
            r = v;
        end
        return r[2:0];
    endfunction

endpackage

// ===== rtl/multicast_mesh_router_core.sv =====
// Channel  | Direction | tuser      | tdata (low bit up)                          | tlast
// s_axis   | in        | func       | port,route_key,packet_bytes,credit_count,   | -
//          |           |            | entry_slot,entry_valid,entry_out_mask,      |
//          |           |            | entry_core_mask                             |
// m_axis   | out       | kind       | port_res,route_key_res,packet_bytes_res,    | last
//          |           |            | dest_node,dest_cores,error_code             |
// cfg      | in        | -          | write enable, register index, 8-bit data    | -
//
// Arrivals, credit returns and table writes go through the execute and finish
// states. A tick visits five inputs; each head takes one table slot per cycle
// (up to 16), then a send runs the shared divider and one step per output.
// Results leave through a one-item holding stage and an output register;
// a stalled output halts the sequencer. Reset is synchronous and active low.
module multicast_mesh_router_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // func
    input  logic [63:0] s_axis_tdata,   // port, route_key, packet_bytes, credit_count,
                                        // entry_slot, entry_valid, entry_out_mask,
                                        // entry_core_mask
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // kind
    output logic [63:0] m_axis_tdata,   // port_res, route_key_res, packet_bytes_res,
                                        // dest_node, dest_cores, error_code
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int NP = mmr_pkg::PORT_COUNT;
    localparam int NT = mmr_pkg::TABLE_ENTRIES;
    localparam int QW = mmr_pkg::QW;
    localparam int TW = mmr_pkg::TW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_VISIT = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SEND  = 4'd7;
    localparam logic [3:0] S_CRED  = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    // Configuration registers
    logic [7:0] r_node, r_fb, r_rdly, r_odly;
    logic [3:0] r_qcap;
    logic [4:0] r_links;

    // Router state
    logic [3:0]  r_fill [NP];
    logic [QW-1:0] r_head [NP];
    logic [3:0]  r_cred [NP];
    logic [31:0] r_busy [NP];
    logic [31:0] r_cyc;
    logic [2:0]  r_rr;
    logic        r_halt;
    logic        r_tv [NT];
    logic [15:0] r_tkey [NT];
    logic [4:0]  r_tmask [NT];
    logic [15:0] r_tcores [NT];

    // Sequencer state
    logic [3:0]  r_st, n_st;
    logic [1:0]  r_func;
    logic [2:0]  r_port;
    logic [15:0] r_key;
    logic [11:0] r_bytes;
    logic [3:0]  r_cc;
    logic [TW-1:0] r_slot;
    logic        r_ev;
    logic [4:0]  r_emask;
    logic [15:0] r_ecores;
    logic [2:0]  r_step, r_in, r_p;
    logic [TW-1:0] r_t;
    logic [4:0]  r_used;
    logic [15:0] r_hkey;
    logic [11:0] r_hbytes;
    logic [4:0]  r_mask;
    logic [15:0] r_cores;
    logic [13:0] r_dur;
    mmr_pkg::t_res r_eres;

    // Result holding stage and output register
    logic          r_pv, r_ov, r_olast;
    mmr_pkg::t_res r_pend, r_out;

    logic [3:0] eff_cap;
    logic [3:0] cfg_cap;
    logic [3:0] lim;
    logic [4:0] csum;
    logic       out_free, can_push, blocked, res_push;
    logic [2:0] vin;
    logic [mmr_pkg::QDATA_W-1:0] q_rdata, q_wdata;
    logic [mmr_pkg::QADDR_W-1:0] q_waddr, q_raddr;
    logic       q_we;
    logic [QW-1:0] tail;
    mmr_pkg::t_div_ctl div_in, div_out;
    logic [mmr_pkg::NUM_W-1:0] div_q, flits;
    logic [31:0] h_ready;

    assign eff_cap = (r_qcap == 4'd0) ? 4'd1 :
                     (r_qcap > 4'(mmr_pkg::QUEUE_DEPTH)) ? 4'(mmr_pkg::QUEUE_DEPTH) : r_qcap;
    // Capacity as it will be used once the written value lands
    assign cfg_cap = (i_cfg_wdata[3:0] == 4'd0) ? 4'd1 :
                     (i_cfg_wdata[3:0] > 4'(mmr_pkg::QUEUE_DEPTH)) ?
                     4'(mmr_pkg::QUEUE_DEPTH) : i_cfg_wdata[3:0];
    assign lim      = r_links[r_port] ? eff_cap : 4'd0;
    assign csum     = {1'b0, r_cred[r_port]} + {1'b0, r_cc};
    assign out_free = !r_ov || m_axis_tready;
    assign can_push = !r_pv || out_free;
    assign vin      = mmr_pkg::mod_ports({1'b0, r_rr} + {1'b0, r_step});
    assign tail     = r_head[r_port] + r_fill[r_port][QW-1:0];
    assign h_ready  = q_rdata[59:28];
    assign flits    = (div_q == '0) ? mmr_pkg::NUM_W'(1) : div_q;
    assign res_push = (r_st == S_SEND && r_mask[mmr_pkg::out_bit(r_p)] && can_push)
                      || (r_st == S_CRED && can_push) || (r_st == S_ERR && can_push);

    // Queue storage, one row block per input port
    assign q_we    = (r_st == S_EXEC) && !r_halt && (r_func == mmr_pkg::FUNC_ARRIVE)
                     && (r_port < 3'(NP)) && (r_fill[r_port] < eff_cap);
    assign q_waddr = {r_port, tail};
    assign q_wdata = {r_cyc + {24'd0, r_rdly}, r_bytes, r_key};
    assign q_raddr = {vin, r_head[vin]};

    mmr_ram #(
        .WIDTH (mmr_pkg::QDATA_W),
        .DEPTH (mmr_pkg::Q_ENTRIES)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // Shared divider for the flit count
    assign div_in.start = (r_st == S_CHK) && (r_mask != 5'd0) && !blocked;
    assign div_in.done  = 1'b0;

    mmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_in),
        .i_num   (mmr_pkg::NUM_W'({1'b0, r_hbytes} + {5'd0, r_fb} - 13'd1)),
        .i_den   (r_fb),
        .o_ctl   (div_out),
        .o_quo   (div_q)
    );

    // Check that every chosen output can take a copy
    always_comb begin
        blocked = 1'b0;
        for (int p = 0; p < NP; p++) begin
            if (r_mask[mmr_pkg::out_bit(3'(p))]) begin
                if (!r_links[p] || r_cred[p] == 4'd0 || r_busy[p] > r_cyc || r_used[p]) begin
                    blocked = 1'b1;
                end
            end
        end
    end

    // Next state of the sequencer
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  n_st = s_axis_tvalid ? S_EXEC : S_IDLE;
            S_EXEC: begin
                if (r_halt) begin
                    n_st = S_FIN;
                end else if (r_func == mmr_pkg::FUNC_TICK) begin
                    n_st = S_VISIT;
                end else if (r_func == mmr_pkg::FUNC_ARRIVE && r_port < 3'(NP)
                             && r_fill[r_port] >= eff_cap) begin
                    n_st = S_ERR;
                end else if (r_func == mmr_pkg::FUNC_CREDIT && r_port < 3'(NP)
                             && csum > {1'b0, lim}) begin
                    n_st = S_ERR;
                end else begin
                    n_st = S_FIN;
                end
            end
            S_VISIT: begin
                if (r_step == 3'(NP)) begin
                    n_st = S_FIN;
                end else if (r_fill[vin] != 4'd0) begin
                    n_st = S_HEAD;
                end
            end
            S_HEAD:  n_st = (h_ready > r_cyc) ? S_VISIT : S_SRCH;
            S_SRCH: begin
                if (r_tv[r_t] && r_tkey[r_t] == r_hkey) begin
                    n_st = S_CHK;
                end else if (r_t == TW'(NT - 1)) begin
                    n_st = S_ERR;
                end
            end
            S_CHK: begin
                if (r_mask == 5'd0) begin
                    n_st = S_CRED;
                end else if (blocked) begin
                    n_st = S_VISIT;
                end else begin
                    n_st = S_DIV;
                end
            end
            S_DIV:   n_st = div_out.done ? S_SEND : S_DIV;
            S_SEND: begin
                if (!r_mask[mmr_pkg::out_bit(r_p)]) begin
                    n_st = (r_p == 3'(NP - 1)) ? S_CRED : S_SEND;
                end else if (can_push) begin
                    if (r_cred[r_p] == 4'd0) begin
                        n_st = S_ERR;
                    end else if (r_p == 3'(NP - 1)) begin
                        n_st = S_CRED;
                    end
                end
            end
            S_CRED:  n_st = can_push ? S_VISIT : S_CRED;
            S_ERR:   n_st = can_push ? S_FIN : S_ERR;
            S_FIN:   n_st = (!r_pv || out_free) ? S_IDLE : S_FIN;
            default: n_st = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_st == S_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_node  <= 8'd0;
            r_qcap  <= 4'd8;
            r_fb    <= 8'd32;
            r_rdly  <= 8'd1;
            r_odly  <= 8'd1;
            r_links <= 5'h1F;
            r_cyc   <= '0;
            r_rr    <= '0;
            r_halt  <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            for (int p = 0; p < NP; p++) begin
                r_fill[p] <= '0;
                r_head[p] <= '0;
                r_busy[p] <= '0;
                r_cred[p] <= 4'(mmr_pkg::QUEUE_DEPTH);
            end
            for (int t = 0; t < NT; t++) begin
                r_tv[t] <= 1'b0;
            end
        end else begin
            r_st <= n_st;

            // Configuration writes; capacity and link changes reload credits
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    mmr_pkg::REG_NODE_ID:   r_node <= i_cfg_wdata;
                    mmr_pkg::REG_QUEUE_CAP: begin
                        r_qcap <= i_cfg_wdata[3:0];
                        for (int p = 0; p < NP; p++) begin
                            r_cred[p] <= r_links[p] ? cfg_cap : 4'd0;
                        end
                    end
                    mmr_pkg::REG_FLIT_B:
                        r_fb <= (i_cfg_wdata == 8'd0) ? 8'd1 : i_cfg_wdata;
                    mmr_pkg::REG_ROUTE_DLY:
                        r_rdly <= (i_cfg_wdata == 8'd0) ? 8'd1 : i_cfg_wdata;
                    mmr_pkg::REG_OUT_DLY:
                        r_odly <= (i_cfg_wdata == 8'd0) ? 8'd1 : i_cfg_wdata;
                    mmr_pkg::REG_LINKS: begin
                        r_links <= i_cfg_wdata[4:0];
                        for (int p = 0; p < NP; p++) begin
                            r_cred[p] <= i_cfg_wdata[p] ? eff_cap : 4'd0;
                        end
                    end
                    default: ;
                endcase
            end

            unique case (r_st)
                S_EXEC: begin
                    if (!r_halt) begin
                        unique case (r_func)
                            mmr_pkg::FUNC_ARRIVE: begin
                                if (q_we) begin
                                    r_fill[r_port] <= r_fill[r_port] + 4'd1;
                                end
                            end
                            mmr_pkg::FUNC_CREDIT: begin
                                if (r_port < 3'(NP) && csum <= {1'b0, lim}) begin
                                    r_cred[r_port] <= csum[3:0];
                                end
                            end
                            mmr_pkg::FUNC_TICK: r_cyc <= r_cyc + 32'd1;
                            mmr_pkg::FUNC_TABLE: r_tv[r_slot] <= r_ev;
                            default: ;
                        endcase
                    end
                end
                S_SEND: begin
                    if (r_mask[mmr_pkg::out_bit(r_p)] && can_push
                        && r_cred[r_p] != 4'd0) begin
                        r_cred[r_p] <= r_cred[r_p] - 4'd1;
                        r_busy[r_p] <= r_cyc + {18'd0, r_dur};
                    end
                end
                S_CRED: begin
                    if (can_push) begin
                        r_head[r_in] <= r_head[r_in] + QW'(1);
                        r_fill[r_in] <= r_fill[r_in] - 4'd1;
                        r_rr         <= mmr_pkg::mod_ports({1'b0, r_in} + 4'd1);
                    end
                end
                S_ERR: begin
                    if (can_push) begin
                        r_halt <= 1'b1;
                    end
                end
                default: ;
            endcase

            // Holding stage: a result leaves only once the next is known.
            // The output register drains when taken.
            if (res_push) begin
                if (r_pv) begin
                    r_ov <= 1'b1;
                end else if (r_ov && m_axis_tready) begin
                    r_ov <= 1'b0;
                end
                r_pv <= 1'b1;
            end else if (r_st == S_FIN && r_pv && out_free) begin
                r_ov <= 1'b1;
                r_pv <= 1'b0;
            end else if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && s_axis_tvalid) begin
            r_func   <= s_axis_tuser;
            r_port   <= s_axis_tdata[2:0];
            r_key    <= s_axis_tdata[18:3];
            r_bytes  <= s_axis_tdata[30:19];
            r_cc     <= s_axis_tdata[34:31];
            r_slot   <= s_axis_tdata[35 +: TW];
            r_ev     <= s_axis_tdata[39];
            r_emask  <= s_axis_tdata[44:40];
            r_ecores <= s_axis_tdata[60:45];
        end
        if (r_st == S_EXEC && r_func == mmr_pkg::FUNC_TABLE) begin
            r_tkey[r_slot]   <= r_key;
            r_tmask[r_slot]  <= r_emask;
            r_tcores[r_slot] <= r_ecores;
        end

        unique case (r_st)
            S_EXEC: begin
                r_step <= '0;
                r_used <= '0;
                r_eres <= '{kind: mmr_pkg::KIND_ERROR, port: r_port, key: 16'd0,
                            bytes: 12'd0, node: 8'd0, cores: 16'd0,
                            err: (r_func == mmr_pkg::FUNC_ARRIVE) ?
                                 mmr_pkg::ERR_QUEUE_OVF : mmr_pkg::ERR_CREDIT_OVF};
            end
            S_VISIT: begin
                r_in <= vin;
                r_t  <= '0;
            end
            S_HEAD: begin
                r_hkey   <= q_rdata[15:0];
                r_hbytes <= q_rdata[27:16];
                if (h_ready > r_cyc) begin
                    r_step <= r_step + 3'd1;
                end
            end
            S_SRCH: begin
                r_mask  <= r_tmask[r_t];
                r_cores <= r_tcores[r_t];
                r_t     <= r_t + TW'(1);
                r_eres  <= '{kind: mmr_pkg::KIND_ERROR, port: r_in, key: r_hkey,
                             bytes: r_hbytes, node: 8'd0, cores: 16'd0,
                             err: mmr_pkg::ERR_ROUTE_MISS};
            end
            S_CHK: begin
                r_p <= '0;
                if (r_mask != 5'd0 && blocked) begin
                    r_step <= r_step + 3'd1;
                end
            end
            S_DIV: begin
                r_dur <= {6'd0, r_odly} + {1'b0, flits} - 14'd1;
            end
            S_SEND: begin
                if (!r_mask[mmr_pkg::out_bit(r_p)]) begin
                    r_p <= r_p + 3'd1;
                end else if (can_push) begin
                    r_p       <= r_p + 3'd1;
                    r_used[r_p] <= 1'b1;
                    r_eres    <= '{kind: mmr_pkg::KIND_ERROR, port: r_p, key: 16'd0,
                                   bytes: 12'd0, node: 8'd0, cores: 16'd0,
                                   err: mmr_pkg::ERR_CREDIT_UNF};
                    r_pend    <= '{kind: mmr_pkg::KIND_COPY, port: r_p, key: r_hkey,
                                   bytes: r_hbytes,
                                   node: (r_p == 3'd0) ? r_node : 8'd0,
                                   cores: (r_p == 3'd0) ? r_cores : 16'd0,
                                   err: mmr_pkg::ERR_QUEUE_OVF};
                end
            end
            S_CRED: begin
                if (can_push) begin
                    r_step <= r_step + 3'd1;
                    r_pend <= '{kind: mmr_pkg::KIND_CREDIT, port: r_in, key: 16'd0,
                                bytes: 12'd0, node: 8'd0, cores: 16'd0,
                                err: mmr_pkg::ERR_QUEUE_OVF};
                end
            end
            S_ERR: begin
                if (can_push) begin
                    r_pend <= r_eres;
                end
            end
            default: ;
        endcase

        if (r_st == S_VISIT && r_step != 3'(NP) && r_fill[vin] == 4'd0) begin
            r_step <= r_step + 3'd1;
        end

        // Move the held result to the output register
        if (res_push && r_pv) begin
            r_out   <= r_pend;
            r_olast <= 1'b0;
        end else if (r_st == S_FIN && r_pv && out_free) begin
            r_out   <= r_pend;
            r_olast <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {7'd0, r_out.err, r_out.cores, r_out.node, r_out.bytes,
                            r_out.key, r_out.port};

endmodule

// ===== rtl/mmr_ram.sv =====
module mmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mmr_div.sv =====
module mmr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mmr_pkg::t_div_ctl          i_ctl,
    input  logic [mmr_pkg::NUM_W-1:0]  i_num,
    input  logic [mmr_pkg::DEN_W-1:0]  i_den,
    output mmr_pkg::t_div_ctl          o_ctl,
    output logic [mmr_pkg::NUM_W-1:0]  o_quo
);

    logic [mmr_pkg::DEN_W-1:0] r_rem;
    logic [mmr_pkg::NUM_W-1:0] r_q;
    logic [mmr_pkg::DEN_W-1:0] r_den;
    logic [3:0]                r_cnt;
    logic                      r_run;
    logic                      r_done;
    logic [mmr_pkg::DEN_W:0]   trial;

    assign trial = {r_rem, r_q[mmr_pkg::NUM_W-1]};

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_q   <= i_num;
                r_den <= i_den;
            end else if (r_run) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= mmr_pkg::DEN_W'(trial - {1'b0, r_den});
                    r_q   <= {r_q[mmr_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[mmr_pkg::DEN_W-1:0];
                    r_q   <= {r_q[mmr_pkg::NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(mmr_pkg::NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl.start = r_run;
    assign o_ctl.done  = r_done;
    assign o_quo       = r_q;

endmodule

// ===== tb/mmr_flow_checker.sv =====
// Watches the input, result and register channels of the router, predicts
// the results of every accepted input item and compares them in order.
module mmr_flow_checker
    import mmr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_s_ready,
    input  logic [1:0]          i_s_user,
    input  logic [63:0]         i_s_data,
    input  logic                i_m_valid,
    input  logic                i_m_ready,
    input  logic [1:0]          i_m_user,
    input  logic [63:0]         i_m_data,
    input  logic                i_m_last,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [7:0]          i_cfg_wdata,
    output int                  o_pending,
    output int                  o_fails,
    output logic [4:0][3:0]     o_fill,
    output logic [4:0][3:0]     o_credit,
    output logic [3:0]          o_cap,
    output logic [4:0]          o_links
);

    typedef struct packed {
        t_res res;
        logic last;
    } t_routed;

    // Register copies, with the zero-as-one rule applied on write.
    logic [7:0]  node_id;
    logic [3:0]  cap_reg;
    logic [3:0]  depth_used;
    logic [7:0]  flit_size;
    logic [7:0]  route_wait;
    logic [7:0]  out_wait;
    logic [4:0]  links;

    // Router state.
    logic [15:0] q_key   [5][8];
    logic [11:0] q_bytes [5][8];
    logic [31:0] q_ready [5][8];
    logic [4:0][3:0] fill;
    logic [2:0]  head    [5];
    logic [4:0][3:0] credit;
    logic [31:0] busy_until [5];
    logic [31:0] cycle_cnt;
    logic [2:0]  rr_ptr;
    logic        rt_valid [16];
    logic [15:0] rt_key   [16];
    logic [4:0]  rt_mask  [16];
    logic [15:0] rt_cores [16];
    logic        halted;

    t_routed step_out[$];
    t_routed pending_results[$];
    int      fail_count;

    assign o_fails   = fail_count;
    assign o_fill    = fill;
    assign o_credit  = credit;
    assign o_cap     = depth_used;
    assign o_links   = links;

    // Credit ceiling of a port: the usable depth when linked, else zero.
    function automatic logic [3:0] credit_ceiling(input int p);
        return links[p] ? depth_used : 4'd0;
    endfunction

    // Table mask bit that selects output p; local sits in the top bit.
    function automatic int mask_bit(input int p);
        return (p == 0) ? 4 : p - 1;
    endfunction

    task automatic reload_credits();
        int p;
        if (cap_reg < 4'd1) begin
            depth_used = 4'd1;
        end else if (cap_reg > 4'(QUEUE_DEPTH)) begin
            depth_used = 4'(QUEUE_DEPTH);
        end else begin
            depth_used = cap_reg;
        end
        for (p = 0; p < 5; p++) credit[p] = credit_ceiling(p);
    endtask

    task automatic restore_reset_state();
        int p;
        int t;
        node_id = 8'd0;
        cap_reg = 4'd8;
        flit_size = 8'd32;
        route_wait = 8'd1;
        out_wait = 8'd1;
        links = 5'h1F;
        for (p = 0; p < 5; p++) begin
            fill[p] = 4'd0;
            head[p] = 3'd0;
            busy_until[p] = 32'd0;
        end
        for (t = 0; t < 16; t++) begin
            rt_valid[t] = 1'b0;
            rt_key[t] = 16'd0;
            rt_mask[t] = 5'd0;
            rt_cores[t] = 16'd0;
        end
        cycle_cnt = 32'd0;
        rr_ptr = 3'd0;
        halted = 1'b0;
        pending_results.delete();
        step_out.delete();
        reload_credits();
    endtask

    task automatic apply_register(input logic [2:0] addr, input logic [7:0] data);
        case (addr)
            REG_NODE_ID: begin
                node_id = data;
            end
            REG_QUEUE_CAP: begin
                cap_reg = data[3:0];
                reload_credits();
            end
            REG_FLIT_B: begin
                flit_size = (data == 8'd0) ? 8'd1 : data;
            end
            REG_ROUTE_DLY: begin
                route_wait = (data == 8'd0) ? 8'd1 : data;
            end
            REG_OUT_DLY: begin
                out_wait = (data == 8'd0) ? 8'd1 : data;
            end
            REG_LINKS: begin
                links = data[4:0];
                reload_credits();
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_result(input logic [1:0] kind, input int port, input logic [15:0] key,
                              input logic [11:0] bytes, input logic [7:0] node,
                              input logic [15:0] cores, input logic [1:0] err);
        t_routed r;
        r.res.kind  = kind;
        r.res.port  = 3'(port);
        r.res.key   = key;
        r.res.bytes = bytes;
        r.res.node  = node;
        r.res.cores = cores;
        r.res.err   = err;
        r.last      = 1'b0;
        step_out.insert(step_out.size(), r);
    endtask

    // Consume the head of input queue p and hand its credit back.
    task automatic retire_head(input int p);
        head[p] = head[p] + 3'd1;
        fill[p] = fill[p] - 4'd1;
        add_result(KIND_CREDIT, p, 16'd0, 12'd0, 8'd0, 16'd0, 2'd0);
        rr_ptr = 3'((p + 1) % 5);
    endtask

    // One tick: advance the cycle and visit the five inputs round-robin.
    task automatic run_tick();
        int step;
        int in_p;
        int t;
        int hit;
        int p;
        logic stop;
        logic blocked;
        logic [4:0] used;
        logic [2:0] hi;
        logic [31:0] flits;
        cycle_cnt = cycle_cnt + 32'd1;
        used = 5'd0;
        stop = 1'b0;
        for (step = 0; step < 5 && !stop; step++) begin
            in_p = (int'(rr_ptr) + step) % 5;
            hi = head[in_p];
            if (fill[in_p] != 4'd0 && q_ready[in_p][hi] <= cycle_cnt) begin
                hit = -1;
                for (t = 0; t < 16; t++) begin
                    if (hit < 0 && rt_valid[t] && rt_key[t] == q_key[in_p][hi]) hit = t;
                end
                if (hit < 0) begin
                    add_result(KIND_ERROR, in_p, q_key[in_p][hi], q_bytes[in_p][hi],
                               8'd0, 16'd0, ERR_ROUTE_MISS);
                    halted = 1'b1;
                    stop = 1'b1;
                end else if (rt_mask[hit] == 5'd0) begin
                    retire_head(in_p);
                end else begin
                    blocked = 1'b0;
                    for (p = 0; p < 5; p++) begin
                        if (rt_mask[hit][mask_bit(p)]) begin
                            if (!links[p] || credit[p] == 4'd0) blocked = 1'b1;
                            if (busy_until[p] > cycle_cnt || used[p]) blocked = 1'b1;
                        end
                    end
                    if (!blocked) begin
                        flits = (32'(q_bytes[in_p][hi]) + 32'(flit_size) - 32'd1)
                                / 32'(flit_size);
                        if (flits == 32'd0) flits = 32'd1;
                        for (p = 0; p < 5 && !stop; p++) begin
                            if (rt_mask[hit][mask_bit(p)]) begin
                                if (p == 0) begin
                                    add_result(KIND_COPY, p, q_key[in_p][hi],
                                               q_bytes[in_p][hi], node_id, rt_cores[hit],
                                               2'd0);
                                end else begin
                                    add_result(KIND_COPY, p, q_key[in_p][hi],
                                               q_bytes[in_p][hi], 8'd0, 16'd0, 2'd0);
                                end
                                if (credit[p] == 4'd0) begin
                                    add_result(KIND_ERROR, p, 16'd0, 12'd0, 8'd0, 16'd0,
                                               ERR_CREDIT_UNF);
                                    halted = 1'b1;
                                    stop = 1'b1;
                                end else begin
                                    credit[p] = credit[p] - 4'd1;
                                    busy_until[p] = cycle_cnt + 32'(out_wait) + flits - 32'd1;
                                    used[p] = 1'b1;
                                end
                            end
                        end
                        if (!stop) retire_head(in_p);
                    end
                end
            end
        end
    endtask

    // Predict the results of one accepted input item.
    task automatic forward_item(input logic [1:0] func, input logic [63:0] d);
        logic [2:0]  port;
        logic [3:0]  slot;
        logic [4:0]  sum;
        logic [2:0]  wr;
        t_routed     r;
        int          p;
        port = d[2:0];
        slot = d[38:35];
        p = int'(port);
        step_out.delete();
        if (!halted) begin
            case (func)
                FUNC_ARRIVE: begin
                    if (p < 5) begin
                        if (fill[p] >= depth_used) begin
                            add_result(KIND_ERROR, p, 16'd0, 12'd0, 8'd0, 16'd0,
                                       ERR_QUEUE_OVF);
                            halted = 1'b1;
                        end else begin
                            wr = head[p] + fill[p][2:0];
                            q_key[p][wr] = d[18:3];
                            q_bytes[p][wr] = d[30:19];
                            q_ready[p][wr] = cycle_cnt + 32'(route_wait);
                            fill[p] = fill[p] + 4'd1;
                        end
                    end
                end
                FUNC_CREDIT: begin
                    if (p < 5) begin
                        sum = 5'(credit[p]) + 5'(d[34:31]);
                        if (sum > 5'(credit_ceiling(p))) begin
                            add_result(KIND_ERROR, p, 16'd0, 12'd0, 8'd0, 16'd0,
                                       ERR_CREDIT_OVF);
                            halted = 1'b1;
                        end else begin
                            credit[p] = sum[3:0];
                        end
                    end
                end
                FUNC_TICK: begin
                    run_tick();
                end
                default: begin
                    rt_valid[slot] = d[39];
                    rt_key[slot]   = d[18:3];
                    rt_mask[slot]  = d[44:40];
                    rt_cores[slot] = d[60:45];
                end
            endcase
        end
        // The final result of the item carries the last flag.
        if (step_out.size() > 0) begin
            r = step_out[step_out.size() - 1];
            r.last = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
        pending_results = {pending_results, step_out};
        step_out.delete();
    endtask

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        fail_count++;
        $display("mismatch: %s expected %0h got %0h", what, want, got);
    endtask

    task automatic check_result();
        t_routed w;
        if (pending_results.size() == 0) begin
            log_mismatch("result with nothing pending, kind", 0, 32'(i_m_user));
        end else begin
            w = pending_results[0];
            pending_results.delete(0);
            if (i_m_user != w.res.kind)
                log_mismatch("kind", 32'(w.res.kind), 32'(i_m_user));
            if (i_m_data[2:0] != w.res.port)
                log_mismatch("port", 32'(w.res.port), 32'(i_m_data[2:0]));
            if (i_m_data[18:3] != w.res.key)
                log_mismatch("route key", 32'(w.res.key), 32'(i_m_data[18:3]));
            if (i_m_data[30:19] != w.res.bytes)
                log_mismatch("packet bytes", 32'(w.res.bytes), 32'(i_m_data[30:19]));
            if (i_m_data[38:31] != w.res.node)
                log_mismatch("dest node", 32'(w.res.node), 32'(i_m_data[38:31]));
            if (i_m_data[54:39] != w.res.cores)
                log_mismatch("dest cores", 32'(w.res.cores), 32'(i_m_data[54:39]));
            if (i_m_data[56:55] != w.res.err)
                log_mismatch("error code", 32'(w.res.err), 32'(i_m_data[56:55]));
            if (i_m_last != w.last)
                log_mismatch("last", 32'(w.last), 32'(i_m_last));
        end
    endtask

    initial begin
        fail_count = 0;
        o_pending = 0;
    end

    // Results are compared before the input of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_reset_state();
        end else begin
            if (i_m_valid && i_m_ready) check_result();
            if (i_cfg_we) apply_register(i_cfg_addr, i_cfg_wdata);
            if (i_s_valid && i_s_ready) forward_item(i_s_user, i_s_data);
        end
        o_pending <= pending_results.size();
    end

endmodule

// ===== tb/tb_multicast_mesh_router_core.sv =====
// Stimulus and verdict for the multicast mesh router.
module tb_multicast_mesh_router_core;
    import mmr_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;   // func
    logic [63:0] s_axis_tdata;   // port, route_key, packet_bytes, credit_count,
                                 // entry_slot, entry_valid, entry_out_mask, entry_core_mask
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  m_axis_tuser;   // kind
    logic [63:0] m_axis_tdata;   // port_res, route_key_res, packet_bytes_res,
                                 // dest_node, dest_cores, error_code
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [7:0]  i_cfg_wdata;

    int              pending;
    int              fails;
    logic [4:0][3:0] fill_seen;
    logic [4:0][3:0] credit_seen;
    logic [3:0]      cap_seen;
    logic [4:0]      links_seen;

    logic [15:0] route_keys [8];
    logic        send_calm;
    logic        recv_calm;
    int          recv_stall;
    int          idle_cycles;

    multicast_mesh_router_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    mmr_flow_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_user(s_axis_tuser), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_user(m_axis_tuser), .i_m_data(m_axis_tdata), .i_m_last(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_pending(pending), .o_fails(fails),
        .o_fill(fill_seen), .o_credit(credit_seen), .o_cap(cap_seen), .o_links(links_seen)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver stalls: mostly short, a few long, with calm stretches.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) recv_calm <= ~recv_calm;
        if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (!recv_calm && $urandom_range(0, 99) < 15) begin
            recv_stall <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else if (!recv_calm && $urandom_range(0, 99) < 3) begin
            recv_stall <= $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_multicast_mesh_router_core: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pack_item(input logic [2:0] port, input logic [15:0] key,
                                              input logic [11:0] bytes, input logic [3:0] cc,
                                              input logic [3:0] slot, input logic valid,
                                              input logic [4:0] mask, input logic [15:0] cores);
        return {3'b000, cores, mask, valid, slot, cc, bytes, key, port};
    endfunction

    // Item with every field random; callers overwrite what matters.
    function automatic logic [63:0] noise_item();
        return {3'b000, 61'({$urandom, $urandom})};
    endfunction

    task automatic idle_gap();
        int g;
        int r;
        r = $urandom_range(0, 99);
        if (send_calm || r < 60) begin
            g = 1;
        end else if (r < 92) begin
            g = $urandom_range(2, 5);
        end else begin
            g = $urandom_range(10, 40);
        end
        repeat (g) @(posedge i_clk);
    endtask

    // Present one item and hold it until the router takes it.
    task automatic push_item(input logic [1:0] func, input logic [63:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_item(input logic [1:0] func, input logic [63:0] d);
        idle_gap();
        push_item(func, d);
    endtask

    task automatic table_write(input logic [3:0] slot, input logic valid,
                               input logic [15:0] key, input logic [4:0] mask,
                               input logic [15:0] cores);
        logic [63:0] d;
        d = noise_item();
        d[18:3] = key;
        d[38:35] = slot;
        d[39] = valid;
        d[44:40] = mask;
        d[60:45] = cores;
        send_item(FUNC_TABLE, d);
    endtask

    task automatic arrive(input logic [2:0] port, input logic [15:0] key,
                          input logic [11:0] bytes);
        logic [63:0] d;
        d = noise_item();
        d[2:0] = port;
        d[18:3] = key;
        d[30:19] = bytes;
        send_item(FUNC_ARRIVE, d);
    endtask

    task automatic credit_return(input logic [2:0] port, input logic [3:0] cc);
        logic [63:0] d;
        d = noise_item();
        d[2:0] = port;
        d[34:31] = cc;
        send_item(FUNC_CREDIT, d);
    endtask

    // Wait for every expected result, then for the router to go quiet.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
    endtask

    task automatic phase_setup(input int ph);
        logic [7:0] v [6];
        case (ph)
            0: v = '{8'd255, 8'd8, 8'd255, 8'd1, 8'd1, 8'd31};
            1: v = '{8'd0, 8'd1, 8'd32, 8'd2, 8'd1, 8'd31};
            2: v = '{8'($urandom), 8'd15, 8'd0, 8'd0, 8'd3, 8'd31};
            3: v = '{8'($urandom), 8'd0, 8'd64, 8'd3, 8'd0, 8'($urandom_range(1, 31))};
            4: v = '{8'($urandom), 8'd4, 8'd1, 8'd1, 8'd2, 8'd0};
            5: v = '{8'($urandom), 8'd6, 8'd16, 8'd255, 8'd255, 8'h15};
            6: v = '{8'd170, 8'd8, 8'd255, 8'd1, 8'd1, 8'd31};
            default: v = '{8'($urandom), 8'($urandom_range(0, 15)), 8'($urandom),
                           8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                           8'($urandom_range(0, 31))};
        endcase
        write_reg(REG_NODE_ID, v[0]);
        write_reg(REG_QUEUE_CAP, v[1]);
        write_reg(REG_FLIT_B, v[2]);
        write_reg(REG_ROUTE_DLY, v[3]);
        write_reg(REG_OUT_DLY, v[4]);
        write_reg(REG_LINKS, v[5]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Table setup, extreme fields, drops, ignored ports and a few ticks.
    task automatic directed_items();
        int s;
        table_write(4'd0, 1'b1, route_keys[0], 5'h1F, 16'hFFFF);
        table_write(4'd1, 1'b1, route_keys[1], 5'h00, 16'h0000);
        table_write(4'd2, 1'b1, route_keys[2], 5'h10, 16'hA5A5);
        for (s = 3; s < 8; s++) begin
            table_write(4'(s), 1'b1, route_keys[s], 5'($urandom_range(1, 31)),
                        16'($urandom));
        end
        // A later duplicate of one key and an invalid duplicate of another.
        table_write(4'd14, 1'b1, route_keys[2], 5'h01, 16'h1234);
        table_write(4'd15, 1'b0, route_keys[0], 5'h02, 16'h0000);
        arrive(3'd0, route_keys[0], 12'd4095);
        arrive(3'd4, route_keys[1], 12'd0);
        arrive(3'd1, route_keys[2], 12'd1);
        arrive(3'd2, route_keys[3], 12'd33);
        arrive(3'd5, route_keys[0], 12'd10);
        credit_return(3'd7, 4'd15);
        repeat (4) send_item(FUNC_TICK, noise_item());
        credit_return(3'd0, 4'd0);
        repeat (3) send_item(FUNC_TICK, noise_item());
    endtask

    // One random item chosen against the current queue and credit state.
    task automatic random_item(output bit counted);
        int r;
        int p;
        int room;
        logic [3:0] slot;
        logic [63:0] d;
        logic [1:0] func;
        idle_gap();
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 4);
        d = noise_item();
        counted = 1'b1;
        func = FUNC_TICK;
        if (r < 5) begin
            counted = 1'b0;
            func = $urandom_range(0, 1) ? FUNC_ARRIVE : FUNC_CREDIT;
            d[2:0] = 3'($urandom_range(5, 7));
        end else if (r < 40) begin
            if (fill_seen[p] < cap_seen) begin
                func = FUNC_ARRIVE;
                d[2:0] = 3'(p);
                d[18:3] = route_keys[$urandom_range(0, 7)];
                d[30:19] = ($urandom_range(0, 99) < 4) ? 12'($urandom) :
                           12'($urandom_range(0, 80));
            end
        end else if (r < 76) begin
            func = FUNC_TICK;
        end else if (r < 88) begin
            room = (links_seen[p] ? int'(cap_seen) : 0) - int'(credit_seen[p]);
            func = FUNC_CREDIT;
            d[2:0] = 3'(p);
            d[34:31] = 4'($urandom_range(0, room));
        end else begin
            func = FUNC_TABLE;
            slot = 4'($urandom_range(0, 15));
            d[38:35] = slot;
            if (slot < 4'd8) begin
                // Slots below eight always hold a valid entry for their key.
                d[18:3] = route_keys[slot];
                d[39] = 1'b1;
                d[44:40] = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom);
            end else if ($urandom_range(0, 1)) begin
                d[18:3] = route_keys[$urandom_range(0, 7)];
            end
        end
        push_item(func, d);
    endtask

    initial begin
        int ph;
        int n;
        int k;
        bit counted;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= 2'd0;
        s_axis_tdata <= 64'd0;
        m_axis_tready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= 3'd0;
        i_cfg_wdata <= 8'd0;
        recv_calm <= 1'b0;
        recv_stall <= 0;
        idle_cycles <= 0;
        send_calm = 1'b0;
        route_keys[0] = 16'h0000;
        route_keys[1] = 16'hFFFF;
        for (k = 2; k < 8; k++) route_keys[k] = 16'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < 8; ph++) begin
            drain();
            phase_setup(ph);
            if (ph == 0) directed_items();
            n = 0;
            while (n < 60) begin
                random_item(counted);
                if (counted) n++;
            end
        end

        // A credit return far beyond any ceiling halts the router.
        drain();
        credit_return(3'($urandom_range(0, 4)), 4'd15);
        send_item(FUNC_TICK, noise_item());
        drain();

        if (fails == 0 && pending == 0) begin
            $display("tb_multicast_mesh_router_core: PASS");
        end else begin
            $display("tb_multicast_mesh_router_core: FAIL");
        end
        $finish;
    end

endmodule
